@@ hw/rtl/bgr2ycc_pkg.sv @@
// ----------------------------------------------------------------------------
// bgr2ycc_pkg
// Shared types and constants of the BGRA to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package bgr2ycc_pkg;

	// Line buffer sizing
	localparam int MAX_WIDTH_DEF = 4096;

	// Row counter and frame height limit
	localparam int           ROW_W      = 12;
	localparam logic [12:0]  MAX_HEIGHT = 13'd4096;

	// Configuration register map
	localparam logic         REG_FRAME_WIDTH  = 1'b0;
	localparam logic         REG_FRAME_HEIGHT = 1'b1;
	localparam logic [12:0]  FRAME_WIDTH_RST  = 13'd1920;
	localparam logic [12:0]  FRAME_HEIGHT_RST = 13'd1080;

	// BT.601 studio-range coefficients, 8 fractional bits
	localparam logic signed [16:0] K_Y_R  = 17'sd66;
	localparam logic signed [16:0] K_Y_G  = 17'sd129;
	localparam logic signed [16:0] K_Y_B  = 17'sd25;
	localparam logic signed [16:0] K_CB_R = -17'sd38;
	localparam logic signed [16:0] K_CB_G = -17'sd74;
	localparam logic signed [16:0] K_CB_B = 17'sd112;
	localparam logic signed [16:0] K_CR_R = 17'sd112;
	localparam logic signed [16:0] K_CR_G = -17'sd94;
	localparam logic signed [16:0] K_CR_B = -17'sd18;
	localparam logic signed [16:0] K_ROUND = 17'sd128;
	localparam logic [7:0]         Y_OFFSET = 8'd16;
	localparam logic [7:0]         C_OFFSET = 8'd128;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Per-channel sum of a horizontal pixel pair
	typedef struct packed {
		logic [8:0] red;
		logic [8:0] green;
		logic [8:0] blue;
	} pair_sum_t;

endpackage

@@ hw/rtl/bgr2ycc_line_buf.sv @@
// ----------------------------------------------------------------------------
// bgr2ycc_line_buf
// Line buffer of pair sums: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bgr2ycc_line_buf #(
	parameter int DEPTH  = bgr2ycc_pkg::MAX_WIDTH_DEF / 2,
	parameter int ADDR_W = 11
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [ADDR_W-1:0]      wr_addr,
	input  bgr2ycc_pkg::pair_sum_t wr_data,
	input  logic                   rd_en,
	input  logic [ADDR_W-1:0]      rd_addr,
	output bgr2ycc_pkg::pair_sum_t rd_data
);

	bgr2ycc_pkg::pair_sum_t mem [DEPTH];
	bgr2ycc_pkg::pair_sum_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/bgra_to_ycbcr420_converter.sv @@
// ----------------------------------------------------------------------------
// bgra_to_ycbcr420_converter
// BGRA pixel stream to BT.601 studio-range luma plus 4:2:0 Cb/Cr.
// ----------------------------------------------------------------------------
//
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-------------------------------------
// s_axis    | in  | tvalid/tready          | tdata: blue, green, red
// m_axis    | out | tvalid/tready          | tdata: luma, cb, cr; tuser; tlast
// cfg       | in  | cfg_we (no wait)       | cfg_addr, cfg_wdata
//
// One pixel per clock sustained while m_axis does not stall; a pixel passes the
// stage 1, stage 2 and output registers (line-buffer read, luma and 2x2 avg, Cb/Cr).
// The rate is set by the single-port-per-direction line buffer: each pixel
// makes at most one write (even rows) or one read (odd rows).
// Reset clears counters, the left-pixel register, stage valids and restores
// the frame size registers; the line buffer is not cleared.
// A stall on m_axis backs up one stage at a time; s_axis_tready drops only
// once every stage holds an item.
//
module bgra_to_ycbcr420_converter #(
	parameter int MAX_WIDTH = bgr2ycc_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// pixel in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red

	// YCbCr out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
	output logic        m_axis_tuser,   // [0] chroma_valid
	output logic        m_axis_tlast,   // frame_end

	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [12:0] cfg_wdata
);

	// column counter must cover MAX_WIDTH-1; at least two bits so the
	// pair index keeps one bit
	localparam int COL_W      = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
	localparam int ADDR_W     = COL_W - 1;
	localparam int LINE_DEPTH = (MAX_WIDTH / 2 < 1) ? 1 : MAX_WIDTH / 2;
	localparam logic [13:0] MAX_W_EVEN = 14'(MAX_WIDTH - (MAX_WIDTH % 2));

	// ---------------------------------------------------------------- config
	logic [12:0] frame_width_q;
	logic [12:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= bgr2ycc_pkg::FRAME_WIDTH_RST;
			frame_height_q <= bgr2ycc_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bgr2ycc_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				bgr2ycc_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
			endcase
		end
	end

	// effective frame size: even width clamped to 2..MAX_W_EVEN, height to 1..4096
	logic [13:0] width_even;
	logic [13:0] width_eff;
	logic [12:0] height_eff;

	always_comb begin
		width_even = {1'b0, frame_width_q[12:1], 1'b0};
		if (width_even < 14'd2) begin
			width_eff = 14'd2;
		end else if (width_even > MAX_W_EVEN) begin
			width_eff = MAX_W_EVEN;
		end else begin
			width_eff = width_even;
		end
		if (frame_height_q == 13'd0) begin
			height_eff = 13'd1;
		end else if (frame_height_q > bgr2ycc_pkg::MAX_HEIGHT) begin
			height_eff = bgr2ycc_pkg::MAX_HEIGHT;
		end else begin
			height_eff = frame_height_q;
		end
	end

	// ---------------------------------------------------------- flow control
	logic v_s1, v_s2, out_valid_q;
	logic out_en, en_s2, en_s1;
	logic accept;

	assign out_en        = !out_valid_q || m_axis_tready;
	assign en_s2         = !v_s2 || out_en;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign accept        = s_axis_tvalid && en_s1;

	// ------------------------------------------------- stage 0: raster walk
	bgr2ycc_pkg::pixel_t    pix;
	bgr2ycc_pkg::pixel_t    left_q;
	bgr2ycc_pkg::pair_sum_t pair_sum;
	logic [COL_W-1:0]       col_q;
	logic [bgr2ycc_pkg::ROW_W-1:0] row_q;
	logic                   row_last;
	logic                   frame_last;
	logic                   odd_col, odd_row;
	logic                   lb_wr, lb_rd;
	logic [ADDR_W-1:0]      lb_addr;

	assign pix        = bgr2ycc_pkg::pixel_t'(s_axis_tdata);
	assign odd_col    = col_q[0];
	assign odd_row    = row_q[0];
	assign row_last   = (14'(col_q) + 14'd1) >= width_eff;
	assign frame_last = (13'(row_q) + 13'd1) >= height_eff;
	assign lb_addr    = col_q[COL_W-1:1];
	assign lb_wr      = accept && odd_col && !odd_row;
	assign lb_rd      = accept && odd_col && odd_row;

	always_comb begin
		pair_sum.blue  = {1'b0, left_q.blue}  + {1'b0, pix.blue};
		pair_sum.green = {1'b0, left_q.green} + {1'b0, pix.green};
		pair_sum.red   = {1'b0, left_q.red}   + {1'b0, pix.red};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!odd_col) begin
				left_q <= pix;
			end
			if (row_last) begin
				col_q <= '0;
				if (frame_last) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// even rows store the pair sums, odd rows fetch them back
	bgr2ycc_pkg::pair_sum_t line_sum;

	bgr2ycc_line_buf #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (lb_wr),
		.wr_addr (lb_addr),
		.wr_data (pair_sum),
		.rd_en   (lb_rd),
		.rd_addr (lb_addr),
		.rd_data (line_sum)
	);

	// ---------------------------------------------------------- stage 1 regs
	bgr2ycc_pkg::pixel_t    pix_s1;
	bgr2ycc_pkg::pair_sum_t pair_s1;
	logic                   cvalid_s1;
	logic                   fend_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pix;
			pair_s1   <= pair_sum;
			cvalid_s1 <= odd_col && odd_row;
			fend_s1   <= row_last && frame_last;
		end
	end

	// ------------------------------------------- stage 1: luma, 2x2 average
	logic signed [16:0] y_sum;
	logic [9:0]         blk_b, blk_g, blk_r;

	always_comb begin
		y_sum = bgr2ycc_pkg::K_Y_R * signed'(17'(pix_s1.red))
		      + bgr2ycc_pkg::K_Y_G * signed'(17'(pix_s1.green))
		      + bgr2ycc_pkg::K_Y_B * signed'(17'(pix_s1.blue))
		      + bgr2ycc_pkg::K_ROUND;
		blk_b = {1'b0, pair_s1.blue}  + {1'b0, line_sum.blue};
		blk_g = {1'b0, pair_s1.green} + {1'b0, line_sum.green};
		blk_r = {1'b0, pair_s1.red}   + {1'b0, line_sum.red};
	end

	logic [7:0]          luma_s2;
	bgr2ycc_pkg::pixel_t avg_s2;
	logic                cvalid_s2;
	logic                fend_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	// y_sum stays below 2^16, so no clamp is reachable
	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			luma_s2      <= y_sum[15:8] + bgr2ycc_pkg::Y_OFFSET;
			avg_s2.blue  <= blk_b[9:2];
			avg_s2.green <= blk_g[9:2];
			avg_s2.red   <= blk_r[9:2];
			cvalid_s2    <= cvalid_s1;
			fend_s2      <= fend_s1;
		end
	end

	// ------------------------------------------------------ stage 2: Cb, Cr
	logic signed [16:0] ab_x, ag_x, ar_x;
	logic signed [16:0] cb_sum, cr_sum;

	// sums lie in -28432..28688: floor >> 8 plus 128 stays in 16..240
	always_comb begin
		ab_x   = signed'(17'(avg_s2.blue));
		ag_x   = signed'(17'(avg_s2.green));
		ar_x   = signed'(17'(avg_s2.red));
		cb_sum = bgr2ycc_pkg::K_CB_R * ar_x + bgr2ycc_pkg::K_CB_G * ag_x
		       + bgr2ycc_pkg::K_CB_B * ab_x + bgr2ycc_pkg::K_ROUND;
		cr_sum = bgr2ycc_pkg::K_CR_R * ar_x + bgr2ycc_pkg::K_CR_G * ag_x
		       + bgr2ycc_pkg::K_CR_B * ab_x + bgr2ycc_pkg::K_ROUND;
	end

	// ------------------------------------------------------ output register
	logic [7:0] luma_q, cb_q, cr_q;
	logic       cvalid_q, fend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			luma_q   <= luma_s2;
			cvalid_q <= cvalid_s2;
			fend_q   <= fend_s2;
			if (cvalid_s2) begin
				cb_q <= cb_sum[15:8] + bgr2ycc_pkg::C_OFFSET;
				cr_q <= cr_sum[15:8] + bgr2ycc_pkg::C_OFFSET;
			end else begin
				cb_q <= '0;
				cr_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {cr_q, cb_q, luma_q};
	assign m_axis_tuser  = cvalid_q;
	assign m_axis_tlast  = fend_q;

endmodule
